FILE: src/ght_pkg.sv
// Shared types and constants for the generational handle table.
`default_nettype none

package ght_pkg;

   // Fixed field widths of the command and response words.
   localparam int CMD_W     = 2;
   localparam int HANDLE_W  = 24;
   localparam int PAYLOAD_W = 16;
   localparam int STATUS_W  = 2;
   localparam int SLOT_W    = 8;

   // Default table geometry.
   localparam int SLOT_BITS_DEF    = 8;
   localparam int GEN_BITS_DEF     = 16;
   localparam int PAYLOAD_BITS_DEF = 16;

   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLOSE   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
   localparam logic [STATUS_W-1:0] ST_CLOSED  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [HANDLE_W-1:0]  handle_in;
      logic [PAYLOAD_W-1:0] payload_in;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [HANDLE_W-1:0]  handle_out;
      logic [SLOT_W-1:0]    slot_out;
      logic [PAYLOAD_W-1:0] payload_out;
   } rsp_type;

endpackage

`default_nettype wire

FILE: src/ght_slot_mem.sv
// Single-port-read, single-port-write slot entry memory with registered read data.
`default_nettype none

module ght_slot_mem #(
   parameter int ADDR_W = ght_pkg::SLOT_BITS_DEF,
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [0:DEPTH-1];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/generational_handle_table_core.sv
// Top level of the generational handle table: command sequencing, free list and live bits.
//
//   channel   ports                      direction  accepted when
//   request   start, busy, req_word      in         start && !busy at a rising edge
//   response  rsp_valid, rsp_word        out        the edge ending the rsp_valid cycle
//
// The accept edge reads the slot entry from the memory, and the next edge writes
// the entry back, updates the free list and presents the response word for one
// cycle. busy is high from the accept edge until that write-back edge, so no new
// word is taken before the last is written back. Reset is synchronous and needs
// no clearing pass: the live bits clear at once and the entry memory is only
// trusted for slots already handed out. The receiver cannot stall responses.
`default_nettype none

module generational_handle_table_core #(
   parameter int SLOT_BITS    = ght_pkg::SLOT_BITS_DEF,
   parameter int GEN_BITS     = ght_pkg::GEN_BITS_DEF,
   parameter int PAYLOAD_BITS = ght_pkg::PAYLOAD_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire ght_pkg::req_type req_word,
   output logic                  rsp_valid,
   output ght_pkg::rsp_type      rsp_word
);

   localparam int SLOTS   = 1 << SLOT_BITS;
   localparam int CNT_W   = SLOT_BITS + 1;
   localparam int ENT_W   = GEN_BITS + PAYLOAD_BITS + CNT_W;
   localparam logic [CNT_W-1:0] LIST_END = CNT_W'(SLOTS);

   localparam logic [1:0] PICK_REUSE = 2'd0;
   localparam logic [1:0] PICK_FRESH = 2'd1;
   localparam logic [1:0] PICK_FULL  = 2'd2;

   logic                             busy_ff, busy_in;
   logic                             rsp_valid_ff;
   ght_pkg::rsp_type                 rsp_word_ff, rsp_word_in;
   logic [CNT_W-1:0]                 free_head_ff, free_head_in;
   logic [CNT_W-1:0]                 fresh_count_ff, fresh_count_in;
   logic [SLOTS-1:0]                 live_ff, live_in;
   logic [ght_pkg::CMD_W-1:0]        op_ff, op_in;
   logic [1:0]                       pick_ff, pick_in;
   logic [SLOT_BITS-1:0]             slot_ff, slot_in;
   logic [GEN_BITS-1:0]              gen_ff, gen_in;
   logic [PAYLOAD_BITS-1:0]          pay_ff, pay_in;

   logic                             accept;
   logic [ENT_W-1:0]                 rd_data;
   logic                             wr_en;
   logic [ENT_W-1:0]                 wr_data;

   logic [GEN_BITS+ght_pkg::HANDLE_W-1:0]            handle_wide;
   logic [PAYLOAD_BITS+ght_pkg::PAYLOAD_W-1:0]       pay_req_wide;
   logic [GEN_BITS-1:0]                              ent_gen;
   logic [PAYLOAD_BITS-1:0]                          ent_pay;
   logic [CNT_W-1:0]                                 ent_link;
   logic [GEN_BITS-1:0]                              new_gen;
   logic [SLOT_BITS+GEN_BITS+ght_pkg::HANDLE_W-1:0]  mint_wide;
   logic [SLOT_BITS+ght_pkg::SLOT_W-1:0]             slot_wide;
   logic [PAYLOAD_BITS+ght_pkg::PAYLOAD_W-1:0]       pay_out_wide;
   logic                                             issued;
   logic                                             gen_match;
   logic                                             is_live;

   assign accept = start && !busy_ff;

   // Front end: pick the slot to read at the accept edge.
   always_comb begin
      handle_wide  = {{GEN_BITS{1'b0}}, req_word.handle_in};
      pay_req_wide = {{PAYLOAD_BITS{1'b0}}, req_word.payload_in};
      op_in        = req_word.command;
      gen_in       = handle_wide[SLOT_BITS +: GEN_BITS];
      pay_in       = pay_req_wide[PAYLOAD_BITS-1:0];
      pick_in      = PICK_FULL;
      slot_in      = req_word.handle_in[SLOT_BITS-1:0];
      if (req_word.command == ght_pkg::CMD_ALLOC) begin
         priority if (!free_head_ff[SLOT_BITS]) begin
            pick_in = PICK_REUSE;
            slot_in = free_head_ff[SLOT_BITS-1:0];
         end else if (!fresh_count_ff[SLOT_BITS]) begin
            pick_in = PICK_FRESH;
            slot_in = fresh_count_ff[SLOT_BITS-1:0];
         end else begin
            pick_in = PICK_FULL;
            slot_in = '0;
         end
      end
   end

   ght_slot_mem #(
      .ADDR_W (SLOT_BITS),
      .DATA_W (ENT_W)
   ) u_slot_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (slot_in),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_data)
   );

   // Back end: resolve the command against the entry read and write it back.
   always_comb begin
      ent_gen   = rd_data[ENT_W-1 -: GEN_BITS];
      ent_pay   = rd_data[CNT_W +: PAYLOAD_BITS];
      ent_link  = rd_data[CNT_W-1:0];
      issued    = {1'b0, slot_ff} < fresh_count_ff;
      gen_match = ent_gen == gen_ff;
      is_live   = live_ff[slot_ff];
      new_gen   = (pick_ff == PICK_REUSE) ? ent_gen + GEN_BITS'(1) : '0;
      mint_wide = (SLOT_BITS+GEN_BITS+ght_pkg::HANDLE_W)'({new_gen, slot_ff});
      slot_wide = (SLOT_BITS+ght_pkg::SLOT_W)'(slot_ff);
      pay_out_wide = (PAYLOAD_BITS+ght_pkg::PAYLOAD_W)'(ent_pay);

      busy_in        = busy_ff;
      free_head_in   = free_head_ff;
      fresh_count_in = fresh_count_ff;
      live_in        = live_ff;
      wr_en          = 1'b0;
      wr_data        = {ent_gen, ent_pay, ent_link};
      rsp_word_in    = '0;
      rsp_word_in.status   = ght_pkg::ST_INVALID;
      rsp_word_in.slot_out = slot_wide[ght_pkg::SLOT_W-1:0];

      if (accept) begin
         busy_in = 1'b1;
      end

      if (busy_ff) begin
         busy_in = 1'b0;
         unique case (op_ff)
            ght_pkg::CMD_ALLOC: begin
               if (pick_ff == PICK_FULL) begin
                  rsp_word_in.status   = ght_pkg::ST_FULL;
                  rsp_word_in.slot_out = '0;
               end else begin
                  if (pick_ff == PICK_REUSE) begin
                     free_head_in = ent_link;
                  end else begin
                     fresh_count_in = fresh_count_ff + CNT_W'(1);
                  end
                  wr_en            = 1'b1;
                  wr_data          = {new_gen, pay_ff, LIST_END};
                  live_in[slot_ff] = 1'b1;
                  rsp_word_in.status     = ght_pkg::ST_OK;
                  rsp_word_in.handle_out = mint_wide[ght_pkg::HANDLE_W-1:0];
               end
            end
            ght_pkg::CMD_LOOKUP: begin
               if (issued && gen_match && is_live) begin
                  rsp_word_in.status      = ght_pkg::ST_OK;
                  rsp_word_in.payload_out = pay_out_wide[ght_pkg::PAYLOAD_W-1:0];
               end
            end
            ght_pkg::CMD_CLOSE: begin
               if (issued && gen_match) begin
                  if (!is_live) begin
                     rsp_word_in.status = ght_pkg::ST_CLOSED;
                  end else begin
                     // Push the slot on the free list head.
                     wr_en            = 1'b1;
                     wr_data          = {ent_gen, ent_pay, free_head_ff};
                     free_head_in     = {1'b0, slot_ff};
                     live_in[slot_ff] = 1'b0;
                     rsp_word_in.status      = ght_pkg::ST_OK;
                     rsp_word_in.payload_out = pay_out_wide[ght_pkg::PAYLOAD_W-1:0];
                  end
               end
            end
            ght_pkg::CMD_UNKNOWN: begin
               rsp_word_in.slot_out = '0;
            end
            default: begin
               rsp_word_in.slot_out = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         free_head_ff   <= LIST_END;
         fresh_count_ff <= '0;
         live_ff        <= '0;
      end else begin
         busy_ff        <= busy_in;
         rsp_valid_ff   <= busy_ff;
         free_head_ff   <= free_head_in;
         fresh_count_ff <= fresh_count_in;
         live_ff        <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_in;
         pick_ff <= pick_in;
         slot_ff <= slot_in;
         gen_ff  <= gen_in;
         pay_ff  <= pay_in;
      end
      if (busy_ff) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Every accepted word yields exactly one response on the next edge.
   a_one_response: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> rsp_valid_ff && !busy_ff)
      else $error("response did not follow an accepted word");

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_count_ff <= CNT_W'(SLOTS))
      else $error("fresh slot count overran the table");

   // A listed slot must be one that was handed out before.
   a_head_issued: assert property (@(posedge clock) disable iff (reset)
      !free_head_ff[SLOT_BITS] |-> free_head_ff < fresh_count_ff)
      else $error("free list head names a slot never issued");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.status == ght_pkg::ST_FULL |->
         free_head_ff[SLOT_BITS] && fresh_count_ff == CNT_W'(SLOTS))
      else $error("table full reported with slots still available");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the generational handle table core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOT_BITS    = ght_pkg::SLOT_BITS_DEF;
   localparam int GEN_BITS     = ght_pkg::GEN_BITS_DEF;
   localparam int SLOTS        = 1 << SLOT_BITS;
   localparam int RANDOM_ITEMS = 650;
   localparam int POOL_DEPTH   = 64;
   localparam int DRILL_ROWS   = 23;
   localparam longint LIMIT_CYCLES = 1_500_000;
   localparam logic [SLOT_BITS:0] SLOT_TOTAL = (SLOT_BITS+1)'(SLOTS);
   localparam logic [SLOT_BITS:0] LIST_END   = SLOT_TOTAL;

   typedef struct {
      ght_pkg::rsp_type word;
      longint unsigned  stamp;
   } pending_rsp_t;

   typedef struct {
      ght_pkg::req_type word;
      bit               typed;
      ght_pkg::rsp_type want;
   } drill_row_t;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   ght_pkg::req_type req_word = '0;
   logic             rsp_valid;
   ght_pkg::rsp_type rsp_word;

   // Shadow copy of the table, updated at each accepted word.
   bit                            live_bits [SLOTS];
   logic [GEN_BITS-1:0]           gen_of    [SLOTS];
   logic [ght_pkg::PAYLOAD_W-1:0] data_of   [SLOTS];
   logic [SLOT_BITS:0]            next_free [SLOTS];
   logic [SLOT_BITS:0]            free_top;
   logic [SLOT_BITS:0]            issued_cnt;

   pending_rsp_t                 awaited_rsp [$];
   logic [ght_pkg::HANDLE_W-1:0] minted_handles [$];
   int                           error_count = 0;
   longint                       cycle_count = 0;

   drill_row_t drill [DRILL_ROWS] = '{
      '{'{ght_pkg::CMD_LOOKUP,  24'h000000, 16'h0000}, 1'b1,
        '{ght_pkg::ST_INVALID, 24'h0, 8'h00, 16'h0000}},
      '{'{ght_pkg::CMD_CLOSE,   24'hFFFFFF, 16'h0000}, 1'b1,
        '{ght_pkg::ST_INVALID, 24'h0, 8'hFF, 16'h0000}},
      '{'{ght_pkg::CMD_UNKNOWN, 24'hFFFFFF, 16'hFFFF}, 1'b1,
        '{ght_pkg::ST_INVALID, 24'h0, 8'h00, 16'h0000}},
      '{'{ght_pkg::CMD_ALLOC,   24'h000000, 16'hFFFF}, 1'b1,
        '{ght_pkg::ST_OK, 24'h000000, 8'h00, 16'h0000}},
      '{'{ght_pkg::CMD_ALLOC,   24'hFFFFFF, 16'h0000}, 1'b1,
        '{ght_pkg::ST_OK, 24'h000001, 8'h01, 16'h0000}},
      '{'{ght_pkg::CMD_LOOKUP,  24'h000000, 16'h0000}, 1'b1,
        '{ght_pkg::ST_OK, 24'h0, 8'h00, 16'hFFFF}},
      '{'{ght_pkg::CMD_LOOKUP,  24'h000100, 16'h0000}, 1'b1,
        '{ght_pkg::ST_INVALID, 24'h0, 8'h00, 16'h0000}},
      '{'{ght_pkg::CMD_CLOSE,   24'h000001, 16'h0000}, 1'b1,
        '{ght_pkg::ST_OK, 24'h0, 8'h01, 16'h0000}},
      '{'{ght_pkg::CMD_CLOSE,   24'h000001, 16'h0000}, 1'b1,
        '{ght_pkg::ST_CLOSED, 24'h0, 8'h01, 16'h0000}},
      '{'{ght_pkg::CMD_LOOKUP,  24'h000001, 16'h0000}, 1'b1,
        '{ght_pkg::ST_INVALID, 24'h0, 8'h01, 16'h0000}},
      '{'{ght_pkg::CMD_ALLOC,   24'h000000, 16'h1234}, 1'b0, '0},
      '{'{ght_pkg::CMD_LOOKUP,  24'h000001, 16'h0000}, 1'b0, '0},
      '{'{ght_pkg::CMD_CLOSE,   24'h000001, 16'h0000}, 1'b0, '0},
      '{'{ght_pkg::CMD_LOOKUP,  24'h000101, 16'h0000}, 1'b0, '0},
      '{'{ght_pkg::CMD_CLOSE,   24'h000000, 16'h0000}, 1'b0, '0},
      '{'{ght_pkg::CMD_CLOSE,   24'h000101, 16'h0000}, 1'b0, '0},
      '{'{ght_pkg::CMD_ALLOC,   24'h000000, 16'hA5A5}, 1'b0, '0},
      '{'{ght_pkg::CMD_ALLOC,   24'h000000, 16'h5A5A}, 1'b0, '0},
      '{'{ght_pkg::CMD_ALLOC,   24'h000000, 16'h0001}, 1'b0, '0},
      '{'{ght_pkg::CMD_LOOKUP,  24'hFFFF02, 16'h0000}, 1'b0, '0},
      '{'{ght_pkg::CMD_UNKNOWN, 24'h000000, 16'h0000}, 1'b1,
        '{ght_pkg::ST_INVALID, 24'h0, 8'h00, 16'h0000}},
      '{'{ght_pkg::CMD_CLOSE,   24'h000002, 16'h0000}, 1'b0, '0},
      '{'{ght_pkg::CMD_LOOKUP,  24'h000002, 16'h0000}, 1'b0, '0}
   };

   generational_handle_table_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   always #1ns clock = ~clock;

   // Works out the response to one word and updates the shadow table.
   function automatic ght_pkg::rsp_type apply_command(input ght_pkg::req_type w);
      ght_pkg::rsp_type     r;
      logic [SLOT_BITS-1:0] s;
      logic [GEN_BITS-1:0]  g;
      r = '0;
      case (w.command)
         ght_pkg::CMD_ALLOC: begin
            if (free_top != LIST_END) begin
               s = free_top[SLOT_BITS-1:0];
               free_top = next_free[s];
               next_free[s] = LIST_END;
               gen_of[s] = gen_of[s] + GEN_BITS'(1);
            end else if (issued_cnt < SLOT_TOTAL) begin
               s = issued_cnt[SLOT_BITS-1:0];
               issued_cnt = issued_cnt + (SLOT_BITS+1)'(1);
               gen_of[s] = '0;
            end else begin
               r.status = ght_pkg::ST_FULL;
               return r;
            end
            live_bits[s] = 1'b1;
            data_of[s] = w.payload_in;
            r.status = ght_pkg::ST_OK;
            r.handle_out = ght_pkg::HANDLE_W'({gen_of[s], s});
            r.slot_out = ght_pkg::SLOT_W'(s);
         end
         ght_pkg::CMD_UNKNOWN: begin
            r.status = ght_pkg::ST_INVALID;
         end
         default: begin
            s = w.handle_in[SLOT_BITS-1:0];
            g = w.handle_in[SLOT_BITS +: GEN_BITS];
            r.slot_out = ght_pkg::SLOT_W'(s);
            if ({1'b0, s} >= issued_cnt || gen_of[s] != g) begin
               r.status = ght_pkg::ST_INVALID;
            end else if (!live_bits[s]) begin
               r.status = (w.command == ght_pkg::CMD_LOOKUP) ?
                          ght_pkg::ST_INVALID : ght_pkg::ST_CLOSED;
            end else begin
               r.status = ght_pkg::ST_OK;
               r.payload_out = data_of[s];
               if (w.command == ght_pkg::CMD_CLOSE) begin
                  live_bits[s] = 1'b0;
                  next_free[s] = free_top;
                  free_top = {1'b0, s};
               end
            end
         end
      endcase
      return r;
   endfunction

   function automatic bit find_live(output logic [ght_pkg::HANDLE_W-1:0] h);
      int                   first;
      logic [SLOT_BITS-1:0] s;
      first = $urandom_range(0, SLOTS - 1);
      h = '0;
      for (int i = 0; i < SLOTS; i++) begin
         s = SLOT_BITS'(first + i);
         if ({1'b0, s} < issued_cnt && live_bits[s]) begin
            h = ght_pkg::HANDLE_W'({gen_of[s], s});
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Mostly handles the table has really minted, so lookups and closes get past
   // the generation check; the rest are stale, corrupted or plain noise.
   function automatic logic [ght_pkg::HANDLE_W-1:0] pick_handle();
      logic [ght_pkg::HANDLE_W-1:0] h;
      logic [SLOT_BITS-1:0]         s;
      int                           r;
      r = $urandom_range(0, 99);
      h = ght_pkg::HANDLE_W'($urandom());
      if (r < 45 && minted_handles.size() > 0) begin
         h = minted_handles[$urandom_range(0, minted_handles.size() - 1)];
      end else if (r < 65) begin
         void'(find_live(h));
      end else if (r < 90 && issued_cnt > 0) begin
         s = SLOT_BITS'($urandom_range(0, issued_cnt - 1));
         h = ght_pkg::HANDLE_W'({gen_of[s], s});
         if (r >= 80) begin
            h[SLOT_BITS + $urandom_range(0, GEN_BITS - 1)] ^= 1'b1;
         end
      end
      return h;
   endfunction

   function automatic ght_pkg::req_type random_word(input int w_alloc, input int w_look,
                                                    input int w_close);
      ght_pkg::req_type w;
      int               r;
      r = $urandom_range(0, 99);
      w.payload_in = ght_pkg::PAYLOAD_W'($urandom());
      w.handle_in = pick_handle();
      if (r < w_alloc) begin
         w.command = ght_pkg::CMD_ALLOC;
      end else if (r < w_alloc + w_look) begin
         w.command = ght_pkg::CMD_LOOKUP;
      end else if (r < w_alloc + w_look + w_close) begin
         w.command = ght_pkg::CMD_CLOSE;
      end else begin
         w.command = ght_pkg::CMD_UNKNOWN;
      end
      return w;
   endfunction

   // Offers one word after a gap and returns once it has been taken.
   task automatic issue_word(input ght_pkg::req_type w, input int gap, input bit typed,
                             input ght_pkg::rsp_type want,
                             output ght_pkg::rsp_type predicted);
      pending_rsp_t e;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predicted = apply_command(w);
      e.word = typed ? want : predicted;
      e.stamp = $time;
      awaited_rsp.push_back(e);
      if (w.command == ght_pkg::CMD_ALLOC && predicted.status == ght_pkg::ST_OK) begin
         minted_handles.push_back(predicted.handle_out);
         if (minted_handles.size() > POOL_DEPTH) void'(minted_handles.pop_front());
      end
   endtask

   task automatic flag_error(input string what, input ght_pkg::rsp_type want,
                             input ght_pkg::rsp_type got);
      error_count++;
      if (error_count <= 10) begin
         $display("ERROR %s at %0t: expected st=%0d h=%06h slot=%02h pay=%04h",
                  what, $time, want.status, want.handle_out, want.slot_out, want.payload_out);
         $display("      got st=%0d h=%06h slot=%02h pay=%04h",
                  got.status, got.handle_out, got.slot_out, got.payload_out);
      end
   endtask

   // A response belongs to a word taken at an earlier edge, never the same one.
   always @(posedge clock) begin
      pending_rsp_t head;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_rsp.size() == 0 || awaited_rsp[0].stamp >= $time) begin
            flag_error("unexpected response", '0, rsp_word);
         end else begin
            head = awaited_rsp.pop_front();
            if (rsp_word.status !== head.word.status ||
                rsp_word.handle_out !== head.word.handle_out ||
                rsp_word.slot_out !== head.word.slot_out ||
                rsp_word.payload_out !== head.word.payload_out) begin
               flag_error("wrong response", head.word, rsp_word);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      ght_pkg::rsp_type got;
      ght_pkg::req_type w;
      int               n;
      int               len;
      int               kind;
      bit               calm;
      bit               filled;

      for (int i = 0; i < SLOTS; i++) begin
         live_bits[i] = 1'b0;
         gen_of[i] = '0;
         data_of[i] = '0;
         next_free[i] = LIST_END;
      end
      free_top = LIST_END;
      issued_cnt = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (drill[i]) begin
         issue_word(drill[i].word, $urandom_range(0, 8), drill[i].typed, drill[i].want, got);
      end

      n = 0;
      filled = 1'b0;
      while (n < RANDOM_ITEMS) begin
         if (!filled && n >= 150) begin
            // Fill every slot, then knock on the full table a few times.
            while (!(free_top == LIST_END && issued_cnt == SLOT_TOTAL)) begin
               issue_word(random_word(100, 0, 0), $urandom_range(0, 8), 1'b0, '0, got);
               n++;
            end
            repeat (3) begin
               issue_word(random_word(100, 0, 0), $urandom_range(0, 8), 1'b0, '0, got);
               n++;
            end
            filled = 1'b1;
         end else begin
            kind = $urandom_range(0, 2);
            len = $urandom_range(10, 50);
            calm = ($urandom_range(0, 2) == 0);
            repeat (len) begin
               case (kind)
                  0: w = random_word(40, 30, 26);
                  1: w = random_word(15, 25, 56);
                  default: w = random_word(65, 15, 16);
               endcase
               issue_word(w, calm ? 0 : $urandom_range(0, 8), 1'b0, '0, got);
               n++;
            end
         end
      end
      start <= 1'b0;

      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
